[rtl/lfrp_pkg.sv]
// Package for the latest-frame reference-counted buffer pool.
// Holds the command and result transfer types and the operation, status and kind codes.
// No dependencies.
package lfrp_pkg;

	localparam int OPCODE_W = 2;
	localparam int HANDLE_W = 8;
	localparam int GEN_W    = 32;
	localparam int STATUS_W = 3;

	// Operation codes
	localparam logic [OPCODE_W-1:0] OP_PUSH    = 2'd0;
	localparam logic [OPCODE_W-1:0] OP_POLL    = 2'd1;
	localparam logic [OPCODE_W-1:0] OP_RELEASE = 2'd2;

	// Status codes
	localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
	localparam logic [STATUS_W-1:0] ST_NO_NEWER  = 3'd1;
	localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd2;
	localparam logic [STATUS_W-1:0] ST_FULL      = 3'd3;
	localparam logic [STATUS_W-1:0] ST_UNDERFLOW = 3'd4;

	// Result kinds
	localparam logic KIND_HANDBACK = 1'b0;
	localparam logic KIND_FINAL    = 1'b1;

	typedef struct packed {
		logic [OPCODE_W-1:0] opcode;
		logic [HANDLE_W-1:0] frame_handle;
		logic [GEN_W-1:0]    generation;
	} cmd_t;

	typedef struct packed {
		logic                result_kind;
		logic [STATUS_W-1:0] status;
		logic [HANDLE_W-1:0] out_handle;
		logic [GEN_W-1:0]    out_generation;
		logic                last_result;
	} result_t;

endpackage

[rtl/latest_frame_refcount_pool.sv]
// Top level of the latest-frame reference-counted buffer pool.
// Depends on lfrp_pkg for the command/result types and codes.
//
// A command is taken when start is high and busy is low; busy then stays high while a small
// sequencer walks the pool one slot per cycle through a single shared slot read port and
// compare. Each result appears on result with result_valid high for one cycle
// only; the receiver must take every one, there is no back-pressure. Each command ends with
// a result marked last_result, shown in the cycle busy falls. A poll or an unknown opcode
// is answered from one sequencer state; a release walks the slots up to the matching handle,
// or through all of them when none matches, and steps to a second state when the slot is
// freed; a push walks every slot, handing back each unread one, and adds a state if still full.
module latest_frame_refcount_pool #(
	parameter int POOL_DEPTH  = 4,
	parameter int HANDLE_BITS = 8,
	parameter int READER_BITS = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  lfrp_pkg::cmd_t    cmd,
	output logic              result_valid,
	output lfrp_pkg::result_t result
);

	localparam int IDX_W = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1;
	localparam int CNT_W = $clog2(POOL_DEPTH + 1);
	localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(POOL_DEPTH);

	// Sequencer state codes
	localparam logic [2:0] S_IDLE      = 3'd0;
	localparam logic [2:0] S_PUSH_SCAN = 3'd1;
	localparam logic [2:0] S_PUSH_FULL = 3'd2;
	localparam logic [2:0] S_POLL      = 3'd3;
	localparam logic [2:0] S_REL_SCAN  = 3'd4;
	localparam logic [2:0] S_REL_FINAL = 3'd5;
	localparam logic [2:0] S_NOP       = 3'd6;

	// Slot storage, oldest first
	logic [HANDLE_BITS-1:0]     slot_handle_q     [POOL_DEPTH];
	logic [lfrp_pkg::GEN_W-1:0] slot_generation_q [POOL_DEPTH];
	logic [READER_BITS-1:0]     slot_readers_q    [POOL_DEPTH];
	logic [CNT_W-1:0]           slot_count_q, slot_count_d;

	logic [2:0]                 state_q, state_d;
	logic [CNT_W-1:0]           ptr_q, ptr_d;
	logic [HANDLE_BITS-1:0]     hdl_q, in_hdl;
	logic [lfrp_pkg::GEN_W-1:0] gen_q, gen_d;

	logic                       emit;
	lfrp_pkg::result_t          res_d;
	logic                       do_remove, do_append, do_rd_wr;
	logic [READER_BITS-1:0]     rd_new;

	logic [IDX_W-1:0]           ptr_idx, cnt_idx;
	logic [HANDLE_BITS-1:0]     cur_hdl;
	logic [lfrp_pkg::GEN_W-1:0] cur_gen;
	logic [READER_BITS-1:0]     cur_rd;
	logic                       ptr_in_pool;

	logic                       result_valid_q;
	lfrp_pkg::result_t          result_q;

	assign in_hdl      = HANDLE_BITS'(cmd.frame_handle);
	assign ptr_idx     = ptr_q[IDX_W-1:0];
	assign cnt_idx     = slot_count_q[IDX_W-1:0];
	assign cur_hdl     = slot_handle_q[ptr_idx];
	assign cur_gen     = slot_generation_q[ptr_idx];
	assign cur_rd      = slot_readers_q[ptr_idx];
	assign ptr_in_pool = (ptr_q < slot_count_q);

	assign busy         = (state_q != S_IDLE);
	assign result_valid = result_valid_q;
	assign result       = result_q;

	// Sequencer: one slot visited per cycle
	always_comb begin
		state_d      = state_q;
		ptr_d        = ptr_q;
		slot_count_d = slot_count_q;
		gen_d        = gen_q;
		emit         = 1'b0;
		res_d        = '0;
		do_remove    = 1'b0;
		do_append    = 1'b0;
		do_rd_wr     = 1'b0;
		rd_new       = cur_rd;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					gen_d = cmd.generation;
					case (cmd.opcode)
						lfrp_pkg::OP_PUSH: begin
							ptr_d   = '0;
							state_d = S_PUSH_SCAN;
						end
						lfrp_pkg::OP_POLL: begin
							ptr_d   = slot_count_q - CNT_W'(1);
							state_d = S_POLL;
						end
						lfrp_pkg::OP_RELEASE: begin
							ptr_d   = '0;
							state_d = S_REL_SCAN;
						end
						default: state_d = S_NOP;
					endcase
				end
			end
			S_PUSH_SCAN: begin
				if (ptr_in_pool) begin
					if (cur_rd == '0) begin
						// free an unread slot, pool closes up behind it
						emit                 = 1'b1;
						res_d.result_kind    = lfrp_pkg::KIND_HANDBACK;
						res_d.status         = lfrp_pkg::ST_OK;
						res_d.out_handle     = lfrp_pkg::HANDLE_W'(cur_hdl);
						res_d.out_generation = cur_gen;
						do_remove            = 1'b1;
						slot_count_d         = slot_count_q - CNT_W'(1);
					end else begin
						ptr_d = ptr_q + CNT_W'(1);
					end
				end else if (slot_count_q >= DEPTH_C) begin
					// still full: new frame goes straight back
					emit                 = 1'b1;
					res_d.result_kind    = lfrp_pkg::KIND_HANDBACK;
					res_d.status         = lfrp_pkg::ST_OK;
					res_d.out_handle     = lfrp_pkg::HANDLE_W'(hdl_q);
					res_d.out_generation = gen_q;
					state_d              = S_PUSH_FULL;
				end else begin
					do_append            = 1'b1;
					slot_count_d         = slot_count_q + CNT_W'(1);
					emit                 = 1'b1;
					res_d.result_kind    = lfrp_pkg::KIND_FINAL;
					res_d.status         = lfrp_pkg::ST_OK;
					res_d.out_handle     = lfrp_pkg::HANDLE_W'(hdl_q);
					res_d.out_generation = gen_q;
					res_d.last_result    = 1'b1;
					state_d              = S_IDLE;
				end
			end
			S_PUSH_FULL: begin
				emit                 = 1'b1;
				res_d.result_kind    = lfrp_pkg::KIND_FINAL;
				res_d.status         = lfrp_pkg::ST_FULL;
				res_d.out_handle     = lfrp_pkg::HANDLE_W'(hdl_q);
				res_d.out_generation = gen_q;
				res_d.last_result    = 1'b1;
				state_d              = S_IDLE;
			end
			S_POLL: begin
				emit              = 1'b1;
				res_d.result_kind = lfrp_pkg::KIND_FINAL;
				res_d.last_result = 1'b1;
				state_d           = S_IDLE;
				if (slot_count_q != '0 && cur_gen > gen_q) begin
					do_rd_wr             = (cur_rd != '1);
					rd_new               = cur_rd + READER_BITS'(1);
					res_d.status         = lfrp_pkg::ST_OK;
					res_d.out_handle     = lfrp_pkg::HANDLE_W'(cur_hdl);
					res_d.out_generation = cur_gen;
				end else begin
					res_d.status         = lfrp_pkg::ST_NO_NEWER;
					res_d.out_handle     = '0;
					res_d.out_generation = gen_q;
				end
			end
			S_REL_SCAN: begin
				if (!ptr_in_pool) begin
					emit                 = 1'b1;
					res_d.result_kind    = lfrp_pkg::KIND_FINAL;
					res_d.status         = lfrp_pkg::ST_NOT_FOUND;
					res_d.out_handle     = lfrp_pkg::HANDLE_W'(hdl_q);
					res_d.out_generation = '0;
					res_d.last_result    = 1'b1;
					state_d              = S_IDLE;
				end else if (cur_hdl != hdl_q) begin
					ptr_d = ptr_q + CNT_W'(1);
				end else begin
					emit                 = 1'b1;
					res_d.out_handle     = lfrp_pkg::HANDLE_W'(hdl_q);
					res_d.out_generation = cur_gen;
					if (cur_rd == '0) begin
						res_d.result_kind = lfrp_pkg::KIND_FINAL;
						res_d.status      = lfrp_pkg::ST_UNDERFLOW;
						res_d.last_result = 1'b1;
						state_d           = S_IDLE;
					end else begin
						do_rd_wr = 1'b1;
						rd_new   = cur_rd - READER_BITS'(1);
						if (cur_rd == READER_BITS'(1) && slot_count_q > CNT_W'(1)) begin
							// last reader gone: hand the slot back first
							res_d.result_kind = lfrp_pkg::KIND_HANDBACK;
							res_d.status      = lfrp_pkg::ST_OK;
							do_remove         = 1'b1;
							slot_count_d      = slot_count_q - CNT_W'(1);
							gen_d             = cur_gen;
							state_d           = S_REL_FINAL;
						end else begin
							res_d.result_kind = lfrp_pkg::KIND_FINAL;
							res_d.status      = lfrp_pkg::ST_OK;
							res_d.last_result = 1'b1;
							state_d           = S_IDLE;
						end
					end
				end
			end
			S_REL_FINAL: begin
				emit                 = 1'b1;
				res_d.result_kind    = lfrp_pkg::KIND_FINAL;
				res_d.status         = lfrp_pkg::ST_OK;
				res_d.out_handle     = lfrp_pkg::HANDLE_W'(hdl_q);
				res_d.out_generation = gen_q;
				res_d.last_result    = 1'b1;
				state_d              = S_IDLE;
			end
			S_NOP: begin
				emit              = 1'b1;
				res_d.result_kind = lfrp_pkg::KIND_FINAL;
				res_d.status      = lfrp_pkg::ST_OK;
				res_d.last_result = 1'b1;
				state_d           = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			slot_count_q   <= '0;
			ptr_q          <= '0;
			result_valid_q <= 1'b0;
		end else begin
			state_q        <= state_d;
			slot_count_q   <= slot_count_d;
			ptr_q          <= ptr_d;
			result_valid_q <= emit;
		end
	end

	// Command latch and result register
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && start) begin
			hdl_q <= in_hdl;
		end
		gen_q <= gen_d;
		if (emit) begin
			result_q <= res_d;
		end
	end

	// Slot storage: close-up shift on removal, append at the tail, reader update at ptr
	always_ff @(posedge clk) begin
		if (do_remove) begin
			for (int k = 0; k < POOL_DEPTH - 1; k++) begin
				if (CNT_W'(k) >= ptr_q) begin
					slot_handle_q[k]     <= slot_handle_q[k+1];
					slot_generation_q[k] <= slot_generation_q[k+1];
					slot_readers_q[k]    <= slot_readers_q[k+1];
				end
			end
		end else if (do_append) begin
			slot_handle_q[cnt_idx]     <= hdl_q;
			slot_generation_q[cnt_idx] <= gen_q;
			slot_readers_q[cnt_idx]    <= '0;
		end else if (do_rd_wr) begin
			slot_readers_q[ptr_idx] <= rd_new;
		end
	end

endmodule

[rtl/lfrp_checker.sv]
// Port-level checker for the latest-frame buffer pool, with its bind to the top level.
// Depends on lfrp_pkg for the result type and codes.
module lfrp_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              start,
	input logic              busy,
	input logic              result_valid,
	input lfrp_pkg::result_t result
);

	// an accepted command always makes the block busy
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("accepted command did not raise busy");

	// the final result is shown exactly as busy drops
	a_fall_final: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> result_valid && result.last_result)
		else $error("busy fell without a final result");

	// no result is produced out of an idle cycle
	a_idle_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		!busy |=> !result_valid)
		else $error("result after an idle cycle");

	// hand-backs are never final and carry ok status
	a_kind: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (result.last_result == (result.result_kind == lfrp_pkg::KIND_FINAL)) &&
		(result.result_kind == lfrp_pkg::KIND_FINAL || result.status == lfrp_pkg::ST_OK))
		else $error("result kind, status and last flag disagree");

endmodule

bind latest_frame_refcount_pool lfrp_checker u_lfrp_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.start        (start),
	.busy         (busy),
	.result_valid (result_valid),
	.result       (result)
);

[tb/latest_frame_refcount_pool_tb.sv]
// Self-checking testbench for latest_frame_refcount_pool: directed and random push/poll/release
// traffic, with a scoreboard class that predicts every result and checks them in order.
// Depends on lfrp_pkg and the latest_frame_refcount_pool RTL.
module latest_frame_refcount_pool_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int         DEPTH        = 4;
	localparam logic [7:0] READERS_FULL = 8'hFF;
	localparam int         RANDOM_ITEMS = 126;
	localparam int         SAT_POLLS    = 258;
	localparam int         DRAIN_CYCLES = 15;
	// opcode with no operation behind it
	localparam logic [lfrp_pkg::OPCODE_W-1:0] OP_UNUSED = 2'd3;

	// Pool tracker: shadow copy of the pool plus the queue of results still to come
	class frame_pool_tracker;
		logic [7:0]        entry_handle[DEPTH];
		logic [31:0]       entry_gen[DEPTH];
		logic [7:0]        entry_readers[DEPTH];
		int unsigned       entry_count;
		lfrp_pkg::result_t pending_results[$];
		int                error_count;

		function new();
			entry_count = 0;
			error_count = 0;
		endfunction

		function void add_expected(logic kind, logic [lfrp_pkg::STATUS_W-1:0] st,
				logic [7:0] h, logic [31:0] g, logic last);
			lfrp_pkg::result_t r;
			r.result_kind    = kind;
			r.status         = st;
			r.out_handle     = h;
			r.out_generation = g;
			r.last_result    = last;
			pending_results = {pending_results, r};
		endfunction

		// Close the gap left by a freed entry, keeping age order
		function void drop_entry(int unsigned idx);
			for (int unsigned k = idx; k + 1 < entry_count; k++) begin
				entry_handle[k]  = entry_handle[k + 1];
				entry_gen[k]     = entry_gen[k + 1];
				entry_readers[k] = entry_readers[k + 1];
			end
			entry_count--;
		endfunction

		// Work out the results of one accepted command and update the shadow pool
		function void note_command(lfrp_pkg::cmd_t c);
			int unsigned i;
			int unsigned top;
			logic [7:0]  h;
			logic [31:0] g;
			h = c.frame_handle;
			case (c.opcode)
			lfrp_pkg::OP_PUSH: begin
				// free every idle entry, oldest first
				i = 0;
				while (i < entry_count) begin
					if (entry_readers[i] == 8'd0) begin
						add_expected(lfrp_pkg::KIND_HANDBACK, lfrp_pkg::ST_OK, entry_handle[i],
							entry_gen[i], 1'b0);
						drop_entry(i);
					end else begin
						i++;
					end
				end
				if (entry_count >= DEPTH) begin
					add_expected(lfrp_pkg::KIND_HANDBACK, lfrp_pkg::ST_OK, h, c.generation, 1'b0);
					add_expected(lfrp_pkg::KIND_FINAL, lfrp_pkg::ST_FULL, h, c.generation, 1'b1);
				end else begin
					entry_handle[entry_count]  = h;
					entry_gen[entry_count]     = c.generation;
					entry_readers[entry_count] = 8'd0;
					entry_count++;
					add_expected(lfrp_pkg::KIND_FINAL, lfrp_pkg::ST_OK, h, c.generation, 1'b1);
				end
			end
			lfrp_pkg::OP_POLL: begin
				if (entry_count > 0 && entry_gen[entry_count - 1] > c.generation) begin
					top = entry_count - 1;
					if (entry_readers[top] != READERS_FULL)
						entry_readers[top]++;
					add_expected(lfrp_pkg::KIND_FINAL, lfrp_pkg::ST_OK, entry_handle[top],
						entry_gen[top], 1'b1);
				end else begin
					add_expected(lfrp_pkg::KIND_FINAL, lfrp_pkg::ST_NO_NEWER, 8'd0,
						c.generation, 1'b1);
				end
			end
			lfrp_pkg::OP_RELEASE: begin
				i = 0;
				while (i < entry_count && entry_handle[i] != h)
					i++;
				if (i >= entry_count) begin
					add_expected(lfrp_pkg::KIND_FINAL, lfrp_pkg::ST_NOT_FOUND, h, 32'd0, 1'b1);
				end else if (entry_readers[i] == 8'd0) begin
					add_expected(lfrp_pkg::KIND_FINAL, lfrp_pkg::ST_UNDERFLOW, h, entry_gen[i],
						1'b1);
				end else begin
					g = entry_gen[i];
					entry_readers[i]--;
					if (entry_readers[i] == 8'd0 && entry_count > 1) begin
						add_expected(lfrp_pkg::KIND_HANDBACK, lfrp_pkg::ST_OK, h, g, 1'b0);
						drop_entry(i);
					end
					add_expected(lfrp_pkg::KIND_FINAL, lfrp_pkg::ST_OK, h, g, 1'b1);
				end
			end
			default: begin
				// unknown opcode: pool untouched, one empty answer
				add_expected(lfrp_pkg::KIND_FINAL, lfrp_pkg::ST_OK, 8'd0, 32'd0, 1'b1);
			end
			endcase
		endfunction

		function void compare_field(string name, logic [31:0] want, logic [31:0] got);
			if (got !== want) begin
				$error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
				error_count++;
			end
		endfunction

		// Check one result transfer against the oldest expectation
		function void check_result(lfrp_pkg::result_t got);
			lfrp_pkg::result_t want;
			if (pending_results.size() == 0) begin
				$error("result with nothing pending: handle 0x%0h generation 0x%0h",
					got.out_handle, got.out_generation);
				error_count++;
				return;
			end
			want = pending_results.pop_front();
			compare_field("result_kind", want.result_kind, got.result_kind);
			compare_field("status", want.status, got.status);
			compare_field("out_handle", want.out_handle, got.out_handle);
			compare_field("out_generation", want.out_generation, got.out_generation);
			compare_field("last_result", want.last_result, got.last_result);
		endfunction
	endclass

	logic              clk    = 1'b0;
	logic              arst_n = 1'b0;
	logic              start  = 1'b0;
	logic              busy;
	lfrp_pkg::cmd_t    cmd    = '0;
	logic              result_valid;
	lfrp_pkg::result_t result;

	frame_pool_tracker tracker = new();
	logic [31:0]       gen_counter = 32'd16;
	bit                no_idle = 1'b0;

	latest_frame_refcount_pool dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.cmd         (cmd),
		.result_valid(result_valid),
		.result      (result)
	);

	always #10 clk = ~clk;

	// Result monitor: every strobed result is checked at the edge that ends it
	always @(posedge clk) begin
		if (arst_n && result_valid === 1'b1)
			tracker.check_result(result);
	end

	// Present one command and hold it until the block takes it; start stays high on return
	task automatic send_command(input logic [1:0] op, input logic [7:0] h, input logic [31:0] g);
		lfrp_pkg::cmd_t c;
		int             gap;
		c.opcode       = op;
		c.frame_handle = h;
		c.generation   = g;
		gap = no_idle ? 0 : $urandom_range(0, 6);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		cmd   <= c;
		forever begin
			@(posedge clk);
			if (busy === 1'b0) begin
				tracker.note_command(c);
				break;
			end
		end
	endtask

	// Pick a handle that is in the pool, or a random one when the pool is empty
	function automatic logic [7:0] live_handle();
		if (tracker.entry_count == 0)
			return 8'($urandom);
		return tracker.entry_handle[$urandom_range(0, tracker.entry_count - 1)];
	endfunction

	// Random traffic: mostly coherent frame streams, some noise
	task automatic random_traffic(input int n);
		int          pick;
		logic [31:0] newest;
		for (int k = 0; k < n; k++) begin
			if (k % 40 == 0)
				no_idle = ($urandom_range(0, 3) == 0);
			pick = $urandom_range(0, 99);
			newest = (tracker.entry_count > 0) ? tracker.entry_gen[tracker.entry_count - 1] : 32'd0;
			if (pick < 32) begin
				if ($urandom_range(0, 9) == 0) begin
					send_command(lfrp_pkg::OP_PUSH, 8'($urandom), $urandom);
				end else begin
					gen_counter = gen_counter + $urandom_range(1, 4);
					send_command(lfrp_pkg::OP_PUSH, 8'($urandom), gen_counter);
				end
			end else if (pick < 64) begin
				case ($urandom_range(0, 5))
				0:       send_command(lfrp_pkg::OP_POLL, 8'($urandom), $urandom);
				1:       send_command(lfrp_pkg::OP_POLL, 8'($urandom), newest);
				default: send_command(lfrp_pkg::OP_POLL, 8'($urandom),
						newest - $urandom_range(1, 3));
				endcase
			end else if (pick < 96) begin
				if ($urandom_range(0, 4) == 0)
					send_command(lfrp_pkg::OP_RELEASE, 8'($urandom), $urandom);
				else
					send_command(lfrp_pkg::OP_RELEASE, live_handle(), $urandom);
			end else begin
				send_command(OP_UNUSED, 8'($urandom), $urandom);
			end
		end
		no_idle = 1'b0;
	endtask

	// Main sequence
	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: empty pool, unknown opcode, field extremes
		send_command(lfrp_pkg::OP_POLL, 8'h00, 32'h0000_0000);
		send_command(lfrp_pkg::OP_RELEASE, 8'h55, 32'h0000_0000);
		send_command(OP_UNUSED, 8'hFF, 32'hFFFF_FFFF);
		send_command(lfrp_pkg::OP_PUSH, 8'h00, 32'h0000_0000);
		send_command(lfrp_pkg::OP_POLL, 8'hFF, 32'h0000_0000);
		send_command(lfrp_pkg::OP_RELEASE, 8'h00, 32'hFFFF_FFFF);
		send_command(lfrp_pkg::OP_PUSH, 8'hFF, 32'hFFFF_FFFF);
		send_command(lfrp_pkg::OP_POLL, 8'h00, 32'hFFFF_FFFE);
		send_command(lfrp_pkg::OP_POLL, 8'h00, 32'hFFFF_FFFF);
		// Fill the pool with read frames, then overflow it
		send_command(lfrp_pkg::OP_PUSH, 8'hA5, 32'h0000_0001);
		send_command(lfrp_pkg::OP_POLL, 8'h00, 32'h0000_0000);
		send_command(lfrp_pkg::OP_PUSH, 8'h5A, 32'h0000_0002);
		send_command(lfrp_pkg::OP_POLL, 8'h00, 32'h0000_0000);
		send_command(lfrp_pkg::OP_PUSH, 8'h3C, 32'h8000_0000);
		send_command(lfrp_pkg::OP_POLL, 8'h00, 32'h0000_0000);
		send_command(lfrp_pkg::OP_PUSH, 8'hC3, 32'h0000_0003);
		// Drain readers: entries freed while others remain, last one stays
		send_command(lfrp_pkg::OP_RELEASE, 8'hA5, 32'h0000_0000);
		send_command(lfrp_pkg::OP_RELEASE, 8'hFF, 32'h0000_0000);
		send_command(lfrp_pkg::OP_RELEASE, 8'h5A, 32'h0000_0000);
		send_command(lfrp_pkg::OP_RELEASE, 8'h3C, 32'h0000_0000);
		send_command(lfrp_pkg::OP_RELEASE, 8'h3C, 32'h0000_0000);
		// Same handle pushed again, then a handle not in the pool released
		send_command(lfrp_pkg::OP_PUSH, 8'h3C, 32'h0000_0005);
		send_command(lfrp_pkg::OP_RELEASE, 8'hC3, 32'h0000_0000);

		// Reader count saturation on the newest entry
		gen_counter = 32'd100;
		send_command(lfrp_pkg::OP_PUSH, 8'h81, gen_counter);
		repeat (SAT_POLLS) send_command(lfrp_pkg::OP_POLL, 8'($urandom), $urandom_range(0, 99));
		send_command(lfrp_pkg::OP_RELEASE, 8'h81, 32'h0000_0000);
		send_command(lfrp_pkg::OP_RELEASE, 8'h81, 32'h0000_0000);

		random_traffic(RANDOM_ITEMS);
		start <= 1'b0;

		// Wait for the remaining results, then drain to catch strays
		while (tracker.pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (tracker.error_count == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

	// Run limit
	initial begin
		#2_000_000;
		$display("RESULT: ERROR");
		$finish;
	end

endmodule

[filelist.f]
rtl/lfrp_pkg.sv
rtl/latest_frame_refcount_pool.sv
rtl/lfrp_checker.sv
tb/latest_frame_refcount_pool_tb.sv
